FILE: sv/bxds_pkg.sv
// Shared types, constants and codes of the box-average image downscaler.
`timescale 1ns / 1ps

package bxds_pkg;

    // Defaults of the top-level parameters.
    localparam int OUT_SIZE_DEF = 100;
    localparam int MAX_DIM_DEF  = 4096;

    // Fixed widths of the interface and of the band sums.
    localparam int PIX_W     = 8;
    localparam int AVG_W     = 8;
    localparam int OUT_IDX_W = 7;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 24;
    localparam int BIT_W     = $clog2(AVG_W);

    // Dimension register value after reset.
    localparam int CFG_DIM_RESET = 100;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(1);

    // Position and end flags of one reduced pixel.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] out_row;
        logic [OUT_IDX_W-1:0] out_col;
        logic                 row_end;
        logic                 image_end;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_HOLD
    } t_bk_state;

endpackage

FILE: sv/bxds_queue.sv
// Small register queue that decouples the front end from the divider back end.
`timescale 1ns / 1ps

module bxds_queue
    import bxds_pkg::*;
#(
    parameter int DATA_W = 64,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_store [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_store[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: sv/bxds_front.sv
// Front end: configuration, raster counters and band column sums; queues finished blocks.
`timescale 1ns / 1ps

module bxds_front
    import bxds_pkg::*;
#(
    parameter int OUT_SIZE = OUT_SIZE_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF,
    parameter int DIM_W    = $clog2(MAX_DIM + 1),
    parameter int QW       = SUM_W + 2 * DIM_W + META_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // pixel input
    input  logic                 i_push,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 o_full,
    // finished blocks towards the queue
    output logic                 o_q_push,
    output logic [QW-1:0]        o_q_data,
    input  logic                 i_q_full
);

    localparam int RC_W  = $clog2(OUT_SIZE);
    localparam int LIM_W = $clog2(MAX_DIM + OUT_SIZE + 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // configuration
    logic [DIM_W-1:0] r_h, r_w;
    logic             cfg_hit;

    // raster position
    logic [DIM_W-1:0] r_src_row, n_src_row;
    logic [DIM_W-1:0] r_src_col, n_src_col;
    logic [DIM_W-1:0] r_rib, n_rib;
    logic [DIM_W-1:0] r_cib, n_cib;
    logic [LIM_W-1:0] r_rlim, n_rlim;
    logic [LIM_W-1:0] r_clim, n_clim;
    logic [RC_W-1:0]  r_rr, n_rr;
    logic [RC_W-1:0]  r_rc, n_rc;

    logic last_col, last_row, blk_col_end, band_end, accept;

    // band sum store with one valid bit per column block
    logic [SUM_W-1:0]    r_mem [OUT_SIZE];
    logic [OUT_SIZE-1:0] r_valid;

    // pixel stage between the store read and the write-back
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [RC_W-1:0]  r_s1_idx;
    logic             r_s1_emit;
    logic [DIM_W-1:0] r_s1_rib1, r_s1_cib1;
    t_meta            r_s1_meta;
    logic [SUM_W-1:0] r_rd_data;
    logic             r_rd_valid;
    logic             r_fwd_valid;
    logic [SUM_W-1:0] r_fwd_data;

    logic [SUM_W-1:0] base, s1_sum, wr_data;
    logic             s1_go;

    assign cfg_hit = i_cfg_valid &&
                     ((i_cfg_index == CFG_IMAGE_HEIGHT) || (i_cfg_index == CFG_IMAGE_WIDTH));

    assign last_col    = ({1'b0, r_src_col} + (DIM_W + 1)'(1)) >= {1'b0, r_w};
    assign last_row    = ({1'b0, r_src_row} + (DIM_W + 1)'(1)) >= {1'b0, r_h};
    // the limit counters hold (position in block + 1) * OUT_SIZE, which reaches the
    // dimension exactly when the ceiling factor is used up
    assign blk_col_end = last_col || (r_clim >= LIM_W'(r_w));
    assign band_end    = last_row || (r_rlim >= LIM_W'(r_h));

    // The entry written back at the edge an item was read is forwarded.
    assign base    = r_fwd_valid ? r_fwd_data : (r_rd_valid ? r_rd_data : '0);
    assign s1_sum  = base + SUM_W'(r_s1_px);
    assign wr_data = r_s1_emit ? '0 : s1_sum;
    assign s1_go   = r_s1_valid && (!r_s1_emit || !i_q_full);

    assign o_full   = r_s1_valid && !s1_go;
    assign accept   = i_push && !o_full;
    assign o_q_push = s1_go && r_s1_emit;
    assign o_q_data = {s1_sum, r_s1_rib1, r_s1_cib1, r_s1_meta};

    always_comb begin
        n_src_row = r_src_row;
        n_src_col = r_src_col;
        n_rib     = r_rib;
        n_cib     = r_cib;
        n_rlim    = r_rlim;
        n_clim    = r_clim;
        n_rr      = r_rr;
        n_rc      = r_rc;
        if (last_col) begin
            n_src_col = '0;
            n_cib     = '0;
            n_clim    = LIM_W'(OUT_SIZE);
            n_rc      = '0;
            if (last_row) begin
                n_src_row = '0;
                n_rib     = '0;
                n_rlim    = LIM_W'(OUT_SIZE);
                n_rr      = '0;
            end else begin
                n_src_row = r_src_row + DIM_W'(1);
                if (band_end) begin
                    n_rib  = '0;
                    n_rlim = LIM_W'(OUT_SIZE);
                    n_rr   = r_rr + RC_W'(1);
                end else begin
                    n_rib  = r_rib + DIM_W'(1);
                    n_rlim = r_rlim + LIM_W'(OUT_SIZE);
                end
            end
        end else begin
            n_src_col = r_src_col + DIM_W'(1);
            if (blk_col_end) begin
                n_cib  = '0;
                n_clim = LIM_W'(OUT_SIZE);
                n_rc   = r_rc + RC_W'(1);
            end else begin
                n_cib  = r_cib + DIM_W'(1);
                n_clim = r_clim + LIM_W'(OUT_SIZE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h        <= clamp_dim(CFG_W'(CFG_DIM_RESET));
            r_w        <= clamp_dim(CFG_W'(CFG_DIM_RESET));
            r_src_row  <= '0;
            r_src_col  <= '0;
            r_rib      <= '0;
            r_cib      <= '0;
            r_rlim     <= LIM_W'(OUT_SIZE);
            r_clim     <= LIM_W'(OUT_SIZE);
            r_rr       <= '0;
            r_rc       <= '0;
            r_valid    <= '0;
            r_s1_valid <= 1'b0;
        end else if (cfg_hit) begin
            // a write to either dimension restarts the image
            if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                r_h <= clamp_dim(i_cfg_data);
            end else begin
                r_w <= clamp_dim(i_cfg_data);
            end
            r_src_row  <= '0;
            r_src_col  <= '0;
            r_rib      <= '0;
            r_cib      <= '0;
            r_rlim     <= LIM_W'(OUT_SIZE);
            r_clim     <= LIM_W'(OUT_SIZE);
            r_rr       <= '0;
            r_rc       <= '0;
            r_valid    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_valid[r_s1_idx] <= 1'b1;
            end
            if (accept) begin
                r_src_row  <= n_src_row;
                r_src_col  <= n_src_col;
                r_rib      <= n_rib;
                r_cib      <= n_cib;
                r_rlim     <= n_rlim;
                r_clim     <= n_clim;
                r_rr       <= n_rr;
                r_rc       <= n_rc;
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_mem[r_s1_idx] <= wr_data;
        end
        if (accept) begin
            r_rd_data   <= r_mem[r_rc];
            r_rd_valid  <= r_valid[r_rc];
            r_fwd_valid <= s1_go && (r_s1_idx == r_rc);
            r_fwd_data  <= wr_data;
            r_s1_px     <= i_pixel_in;
            r_s1_idx    <= r_rc;
            r_s1_emit   <= band_end && blk_col_end;
            r_s1_rib1   <= r_rib + DIM_W'(1);
            r_s1_cib1   <= r_cib + DIM_W'(1);
            r_s1_meta.out_row   <= OUT_IDX_W'(r_rr);
            r_s1_meta.out_col   <= OUT_IDX_W'(r_rc);
            r_s1_meta.row_end   <= last_col;
            r_s1_meta.image_end <= last_col && last_row;
        end
    end

endmodule

FILE: sv/bxds_back.sv
// Back end: block pixel count, restoring divider and the result register.
`timescale 1ns / 1ps

module bxds_back
    import bxds_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int DIM_W   = $clog2(MAX_DIM + 1),
    parameter int QW      = SUM_W + 2 * DIM_W + META_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // finished blocks from the queue
    input  logic                 i_q_empty,
    input  logic [QW-1:0]        i_q_data,
    output logic                 o_q_pop,
    // result side
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [AVG_W-1:0]     o_avg_pixel,
    output logic [OUT_IDX_W-1:0] o_out_row,
    output logic [OUT_IDX_W-1:0] o_out_col,
    output logic                 o_row_end,
    output logic                 o_image_end
);

    localparam int CNT_W = 2 * DIM_W;
    localparam int CMP_W = CNT_W + AVG_W;

    t_bk_state r_state, n_state;

    logic [SUM_W-1:0] r_rem, n_rem;
    logic [DIM_W-1:0] r_fr, n_fr;
    logic [DIM_W-1:0] r_fc, n_fc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [AVG_W-1:0] r_quo, n_quo;
    logic [BIT_W-1:0] r_bit, n_bit;
    t_meta            r_meta, n_meta;

    logic             r_out_valid, n_out_valid;
    logic [AVG_W-1:0] r_out_avg, n_out_avg;
    t_meta            r_out_meta, n_out_meta;

    logic [CMP_W-1:0] trial;
    logic             fits;

    assign trial = CMP_W'(r_cnt) << r_bit;
    assign fits  = CMP_W'(r_rem) >= trial;

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_fr        = r_fr;
        n_fc        = r_fc;
        n_cnt       = r_cnt;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_meta      = r_meta;
        n_out_avg   = r_out_avg;
        n_out_meta  = r_out_meta;
        n_out_valid = r_out_valid && !i_pop;
        o_q_pop     = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_rem   = i_q_data[QW-1 -: SUM_W];
                    n_fr    = i_q_data[QW-SUM_W-1 -: DIM_W];
                    n_fc    = i_q_data[QW-SUM_W-DIM_W-1 -: DIM_W];
                    n_meta  = t_meta'(i_q_data[META_W-1:0]);
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_cnt   = r_fr * r_fc;
                n_quo   = '0;
                n_bit   = BIT_W'(AVG_W - 1);
                n_state = BK_DIV;
            end
            BK_DIV: begin
                // one quotient bit per cycle, most significant first
                if (fits) begin
                    n_rem        = r_rem - SUM_W'(trial);
                    n_quo[r_bit] = 1'b1;
                end
                if (r_bit == '0) begin
                    n_state = BK_HOLD;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            BK_HOLD: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_quo;
                    n_out_meta  = r_meta;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_fr       <= n_fr;
        r_fc       <= n_fc;
        r_cnt      <= n_cnt;
        r_quo      <= n_quo;
        r_bit      <= n_bit;
        r_meta     <= n_meta;
        r_out_avg  <= n_out_avg;
        r_out_meta <= n_out_meta;
    end

    assign o_empty     = !r_out_valid;
    assign o_avg_pixel = r_out_avg;
    assign o_out_row   = r_out_meta.out_row;
    assign o_out_col   = r_out_meta.out_col;
    assign o_row_end   = r_out_meta.row_end;
    assign o_image_end = r_out_meta.image_end;

endmodule

FILE: sv/box_average_image_downscaler.sv
// Top level of the box-average image downscaler: front end, block queue and divider back end.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// pixels    in         i_push / o_full           i_pixel_in
// results   out        o_empty / i_pop           o_avg_pixel, o_out_row, o_out_col,
//                                                o_row_end, o_image_end
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A pixel is taken every cycle while its front stage can move on; each pixel passes through
// the read-add-write stage of the band sum store.
// A finished block passes the back end in order: queue pop, pixel count multiply, eight
// divide steps, hand-off; the back end takes no new block until it has handed off the last.
// The queue holds four finished blocks; when it is full, a finished block stalls the front stage and raises o_full.
// Reset is synchronous and takes effect at once; the band sums read as zero through
// per-entry valid bits, so there is no clearing pass.

module box_average_image_downscaler
    import bxds_pkg::*;
#(
    parameter int OUT_SIZE = OUT_SIZE_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [AVG_W-1:0]     o_avg_pixel,
    output logic [OUT_IDX_W-1:0] o_out_row,
    output logic [OUT_IDX_W-1:0] o_out_col,
    output logic                 o_row_end,
    output logic                 o_image_end
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int QW    = SUM_W + 2 * DIM_W + META_W;

    logic          fq_push, fq_full, qb_empty, qb_pop;
    logic [QW-1:0] fq_data, qb_data;

    assign o_cfg_ready = 1'b1;

    bxds_front #(
        .OUT_SIZE (OUT_SIZE),
        .MAX_DIM  (MAX_DIM),
        .DIM_W    (DIM_W),
        .QW       (QW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_pixel_in  (i_pixel_in),
        .o_full      (o_full),
        .o_q_push    (fq_push),
        .o_q_data    (fq_data),
        .i_q_full    (fq_full)
    );

    bxds_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_data),
        .o_full  (fq_full),
        .i_pop   (qb_pop),
        .o_empty (qb_empty),
        .o_data  (qb_data)
    );

    bxds_back #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .QW      (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (qb_empty),
        .i_q_data    (qb_data),
        .o_q_pop     (qb_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_avg_pixel (o_avg_pixel),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end)
    );

endmodule
